// File: rtl/dwpp_pkg.sv
// dwpp_pkg: shared widths, reset values and codes for the dual wheel pid position block
// no dependencies; imported by dual_wheel_pid_position_top, dwpp_checker and tb_top

package dwpp_pkg;

	localparam int COUNT_BITS = 12;
	localparam int ERR_W      = COUNT_BITS + 1;
	localparam int DIF_W      = COUNT_BITS + 2;
	localparam int ACC_W      = 24;
	localparam int LIM_W      = 23;
	localparam int GAIN_W     = 16;
	localparam int DUTY_W     = 16;
	localparam int FRAC_BITS  = 12;

	// shared multiplier: signed 25 x signed 17
	localparam int MUL_A_W    = 25;
	localparam int MUL_B_W    = GAIN_W + 1;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;

	// controller sum, split into a low unsigned and a high signed part for the scale step
	localparam int SUM_W      = 41;
	localparam int LO_W       = 24;
	localparam int TOT_W      = SUM_W + GAIN_W + 1;
	localparam int SHF_W      = TOT_W - FRAC_BITS;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DAT_W  = LIM_W;

	localparam logic [GAIN_W-1:0] GAIN_P_RST  = GAIN_W'(1147);
	localparam logic [GAIN_W-1:0] GAIN_I_RST  = GAIN_W'(369);
	localparam logic [GAIN_W-1:0] GAIN_D_RST  = GAIN_W'(614);
	localparam logic [LIM_W-1:0]  LIMIT_RST   = LIM_W'(555);
	localparam logic [GAIN_W-1:0] SCALE_RST   = GAIN_W'(5000);
	localparam logic [DUTY_W-1:0] PERIOD_RST  = DUTY_W'(10000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P         = 3'd0,
		REG_GAIN_I         = 3'd1,
		REG_GAIN_D         = 3'd2,
		REG_INTEGRAL_LIMIT = 3'd3,
		REG_OUTPUT_SCALE   = 3'd4,
		REG_PWM_PERIOD     = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_P  = 3'd0,
		OP_I  = 3'd1,
		OP_D  = 3'd2,
		OP_LO = 3'd3,
		OP_HI = 3'd4
	} mul_op_t;

endpackage

// File: rtl/dual_wheel_pid_position_top.sv
// dual wheel pid position controller, top level with the shared multiplier and its sequencer
// depends on dwpp_pkg
//
// usage:
//   input channel (in_valid / in_stall) carries one control tick: target_count,
//   left_count and right_count. in_stall is high while a tick is being worked on.
//   output channel (out_valid / out_stall) carries duty_left, duty_right, move_done.
//   configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes the
//   gains, integral limit, output scale and pwm period; cfg_ready is high when idle.
// sequence: a normal tick runs PREP, then MUL and ACC for each of five products per wheel
//   with FIN after each wheel, then WAIT; a tick that finishes the move goes from PREP
//   straight to WAIT. a new tick is accepted only after the last one has left WAIT. the
//   one 25x17 multiplier is shared, each product registered and then added in the next cycle.
// a finished result sits in the output register; the next tick is accepted while it
//   waits. if the receiver still stalls when the following result is ready, the
//   sequencer holds that result until the output register is free.
// reset (arst_n low) loads the default register values, clears the accumulators and
//   previous errors and drops out_valid.

module dual_wheel_pid_position_top
	import dwpp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COUNT_BITS-1:0] target_count,
	input  logic [COUNT_BITS-1:0] left_count,
	input  logic [COUNT_BITS-1:0] right_count,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DUTY_W-1:0]     duty_left,
	output logic [DUTY_W-1:0]     duty_right,
	output logic                  move_done,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DAT_W-1:0]  cfg_data
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PREP = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_ACC  = 6'b001000,
		ST_FIN  = 6'b010000,
		ST_WAIT = 6'b100000
	} state_t;

	state_t state_q;
	mul_op_t op_q;
	logic wheel_q;

	logic [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q, scale_q;
	logic [LIM_W-1:0]  limit_q;
	logic [DUTY_W-1:0] period_q;

	logic [COUNT_BITS-1:0]   tgt_q;
	logic [COUNT_BITS-1:0]   cnt_q   [2];
	logic signed [ERR_W-1:0] prev_q  [2];
	logic signed [ACC_W-1:0] accum_q [2];
	logic signed [ERR_W-1:0] err_q   [2];
	logic signed [DIF_W-1:0] dif_q   [2];

	logic signed [ERR_W-1:0] err_c   [2];
	logic signed [ACC_W-1:0] acc_c   [2];
	logic signed [DIF_W-1:0] dif_c   [2];
	logic                    done_c;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [TOT_W-1:0]   tot_q;

	logic [SHF_W-1:0]  shf;
	logic [DUTY_W-1:0] duty_c;

	logic [DUTY_W-1:0] dl_q, dr_q, duty_left_q, duty_right_q;
	logic              done_q, move_done_q, out_valid_q;

	assign in_stall   = (state_q != ST_IDLE);
	assign cfg_ready  = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign duty_left  = duty_left_q;
	assign duty_right = duty_right_q;
	assign move_done  = move_done_q;

	// per wheel error, accumulator update and derivative
	always_comb begin
		logic signed [ACC_W:0] acc_sum;
		for (int w = 0; w < 2; w++) begin
			err_c[w] = $signed({1'b0, tgt_q}) - $signed({1'b0, cnt_q[w]});
			acc_sum  = (ACC_W+1)'(accum_q[w]) + (ACC_W+1)'(err_c[w]);
			if (err_c[w] < 0) begin
				if (acc_sum < -(ACC_W+1)'(signed'(1 << (ACC_W - 1))))
					acc_c[w] = {1'b1, {(ACC_W-1){1'b0}}};
				else
					acc_c[w] = acc_sum[ACC_W-1:0];
			end else begin
				acc_c[w] = '0;
			end
			if (acc_c[w] > $signed({1'b0, limit_q}))
				acc_c[w] = $signed({1'b0, limit_q});
			dif_c[w] = DIF_W'(err_c[w]) - DIF_W'(prev_q[w]);
		end
	end

	assign done_c = (cnt_q[0] >= tgt_q) && (cnt_q[1] >= tgt_q);

	// operand selection for the shared multiplier
	always_comb begin
		case (op_q)
			OP_P: begin
				mul_a = MUL_A_W'(err_q[wheel_q]);
				mul_b = $signed({1'b0, gain_p_q});
			end
			OP_I: begin
				mul_a = MUL_A_W'(accum_q[wheel_q]);
				mul_b = $signed({1'b0, gain_i_q});
			end
			OP_D: begin
				mul_a = MUL_A_W'(dif_q[wheel_q]);
				mul_b = $signed({1'b0, gain_d_q});
			end
			OP_LO: begin
				mul_a = MUL_A_W'($unsigned(sum_q[LO_W-1:0]));
				mul_b = $signed({1'b0, scale_q});
			end
			OP_HI: begin
				mul_a = MUL_A_W'($signed(sum_q[SUM_W-1:LO_W]));
				mul_b = $signed({1'b0, scale_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// drop the fraction, then saturate to 0..pwm_period
	assign shf = tot_q[TOT_W-1:FRAC_BITS];
	always_comb begin
		if (tot_q <= 0)
			duty_c = '0;
		else if ((|shf[SHF_W-1:DUTY_W]) || (shf[DUTY_W-1:0] > period_q))
			duty_c = period_q;
		else
			duty_c = shf[DUTY_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_P;
			wheel_q     <= 1'b0;
			out_valid_q <= 1'b0;
			gain_p_q    <= GAIN_P_RST;
			gain_i_q    <= GAIN_I_RST;
			gain_d_q    <= GAIN_D_RST;
			limit_q     <= LIMIT_RST;
			scale_q     <= SCALE_RST;
			period_q    <= PERIOD_RST;
			for (int w = 0; w < 2; w++) begin
				prev_q[w]  <= '0;
				accum_q[w] <= '0;
			end
		end else begin
			if ((state_q == ST_WAIT) && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_GAIN_P:         gain_p_q <= cfg_data[GAIN_W-1:0];
					REG_GAIN_I:         gain_i_q <= cfg_data[GAIN_W-1:0];
					REG_GAIN_D:         gain_d_q <= cfg_data[GAIN_W-1:0];
					REG_INTEGRAL_LIMIT: limit_q  <= cfg_data[LIM_W-1:0];
					REG_OUTPUT_SCALE:   scale_q  <= cfg_data[GAIN_W-1:0];
					REG_PWM_PERIOD:     period_q <= cfg_data[DUTY_W-1:0];
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_PREP;
				end
				ST_PREP: begin
					if (done_c) begin
						for (int w = 0; w < 2; w++) begin
							prev_q[w]  <= '0;
							accum_q[w] <= '0;
						end
						state_q <= ST_WAIT;
					end else begin
						for (int w = 0; w < 2; w++) begin
							prev_q[w]  <= err_c[w];
							accum_q[w] <= acc_c[w];
						end
						wheel_q <= 1'b0;
						op_q    <= OP_P;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (op_q == OP_HI) begin
						state_q <= ST_FIN;
					end else begin
						op_q    <= mul_op_t'(op_q + 3'd1);
						state_q <= ST_MUL;
					end
				end
				ST_FIN: begin
					if (!wheel_q) begin
						wheel_q <= 1'b1;
						op_q    <= OP_P;
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (!out_valid_q || !out_stall)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					tgt_q    <= target_count;
					cnt_q[0] <= left_count;
					cnt_q[1] <= right_count;
				end
			end
			ST_PREP: begin
				for (int w = 0; w < 2; w++) begin
					err_q[w] <= err_c[w];
					dif_q[w] <= dif_c[w];
				end
				done_q <= done_c;
				dl_q   <= '0;
				dr_q   <= '0;
			end
			ST_MUL: begin
				prod_q <= PROD_W'(mul_a * mul_b);
			end
			ST_ACC: begin
				case (op_q)
					OP_P:    sum_q <= SUM_W'(prod_q);
					OP_I:    sum_q <= sum_q + SUM_W'(prod_q);
					OP_D:    sum_q <= sum_q + SUM_W'(prod_q);
					OP_LO:   tot_q <= TOT_W'(prod_q);
					OP_HI:   tot_q <= tot_q + (TOT_W'(prod_q) <<< LO_W);
					default: ;
				endcase
			end
			ST_FIN: begin
				if (!wheel_q)
					dl_q <= duty_c;
				else
					dr_q <= duty_c;
			end
			ST_WAIT: begin
				if (!out_valid_q || !out_stall) begin
					duty_left_q  <= dl_q;
					duty_right_q <= dr_q;
					move_done_q  <= done_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/dwpp_checker.sv
// dwpp_checker: port level assertions for dual_wheel_pid_position_top, with its bind
// depends on dwpp_pkg and the top level's port names

module dwpp_checker
	import dwpp_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [DUTY_W-1:0] duty_left,
	input logic [DUTY_W-1:0] duty_right,
	input logic              move_done
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a finished move always reports zero duty on both wheels
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && move_done |-> (duty_left == '0) && (duty_right == '0))
		else $error("nonzero duty on a finished move");

	// the block is busy right after taking a tick
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted twice in a row");

	// no result can appear the cycle right after an input transaction
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result raised too early");

endmodule

bind dual_wheel_pid_position_top dwpp_checker u_dwpp_checker (.*);

// File: dv/tb_top.sv
// tb_top: self-checking bench for dual_wheel_pid_position_top, random and directed control ticks
// depends on rtl/dwpp_pkg.sv and rtl/dual_wheel_pid_position_top.sv

module tb_top;
	import dwpp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int     CLK_PERIOD    = 12;
	localparam int     RESET_CYCLES  = 5;
	localparam int     MAX_IDLE      = 17;
	localparam int     SETTLE_CYCLES = 40;
	localparam int     LONG_HOLD     = 600;
	localparam int     HOLD_AT       = 80;
	localparam int     CYCLE_LIMIT   = 1200000;
	localparam int     SAT_TICKS     = 40;
	localparam int     CNT_MAX       = (1 << COUNT_BITS) - 1;
	localparam longint ACC_FLOOR     = -(longint'(1) << (ACC_W - 1));

	// indexes past the register map, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [COUNT_BITS-1:0] target, left, right;
	} tick_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty_l, duty_r;
		logic              done;
	} duty_t;

	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  in_valid     = 1'b0;
	logic                  in_stall;
	logic [COUNT_BITS-1:0] target_count = '0;
	logic [COUNT_BITS-1:0] left_count   = '0;
	logic [COUNT_BITS-1:0] right_count  = '0;
	logic                  out_valid;
	logic                  out_stall    = 1'b0;
	logic [DUTY_W-1:0]     duty_left;
	logic [DUTY_W-1:0]     duty_right;
	logic                  move_done;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DAT_W-1:0]  cfg_data     = '0;

	// register shadow
	logic [GAIN_W-1:0] kp_cfg     = GAIN_P_RST;
	logic [GAIN_W-1:0] ki_cfg     = GAIN_I_RST;
	logic [GAIN_W-1:0] kd_cfg     = GAIN_D_RST;
	logic [LIM_W-1:0]  lim_cfg    = LIMIT_RST;
	logic [GAIN_W-1:0] scale_cfg  = SCALE_RST;
	logic [DUTY_W-1:0] period_cfg = PERIOD_RST;

	// per wheel controller state, index 0 left, 1 right
	longint wheel_acc [2]      = '{0, 0};
	longint wheel_prev_err [2] = '{0, 0};

	tick_t tick_q [$];
	duty_t duty_q [$];
	int    ticks_sent  = 0;
	int    ticks_taken = 0;
	int    send_gap    = 0;
	int    recv_wait   = 0;
	int    err_cnt     = 0;
	int    cycle_cnt   = 0;
	logic  idle_on     = 1'b1;
	logic  hold_on     = 1'b0;

	dual_wheel_pid_position_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.target_count (target_count),
		.left_count   (left_count),
		.right_count  (right_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.duty_left    (duty_left),
		.duty_right   (duty_right),
		.move_done    (move_done),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic logic [DUTY_W-1:0] wheel_drive(input int w, input longint err);
		longint a;
		longint d;
		longint total;
		a = wheel_acc[w];
		if (err < 0) begin
			a = a + err;
			if (a < ACC_FLOOR)
				a = ACC_FLOOR;
		end else
			a = 0;
		if (a > longint'(lim_cfg))
			a = longint'(lim_cfg);
		wheel_acc[w] = a;
		d = err - wheel_prev_err[w];
		wheel_prev_err[w] = err;
		total = longint'(kp_cfg) * err + longint'(ki_cfg) * a + longint'(kd_cfg) * d;
		total = total * longint'(scale_cfg);
		if (total <= 0)
			return '0;
		total = total >>> FRAC_BITS;
		if (total > longint'(period_cfg))
			total = longint'(period_cfg);
		return DUTY_W'(total);
	endfunction

	function automatic duty_t predict_duty(input logic [COUNT_BITS-1:0] tgt, lc, rc);
		duty_t r;
		r = '0;
		if (lc >= tgt && rc >= tgt) begin
			// move finished: duties stay 0 and both wheels start over
			wheel_acc[0] = 0;
			wheel_acc[1] = 0;
			wheel_prev_err[0] = 0;
			wheel_prev_err[1] = 0;
			r.done = 1'b1;
		end else begin
			r.duty_l = wheel_drive(0, longint'(tgt) - longint'(lc));
			r.duty_r = wheel_drive(1, longint'(tgt) - longint'(rc));
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint want, input longint got);
		$display("[%0t] mismatch: %s want %0d got %0d", $realtime, what, want, got);
		err_cnt++;
	endtask

	task automatic check_duty(input duty_t got);
		duty_t want;
		if (duty_q.size() == 0) begin
			report_mismatch("result with nothing pending, duty_left", 0, got.duty_l);
			return;
		end
		want = duty_q.pop_front();
		if (got.duty_l !== want.duty_l)
			report_mismatch("duty_left", want.duty_l, got.duty_l);
		if (got.duty_r !== want.duty_r)
			report_mismatch("duty_right", want.duty_r, got.duty_r);
		if (got.done !== want.done)
			report_mismatch("move_done", want.done, got.done);
	endtask

	// driver: offers queued ticks, predicts each one at its transaction
	always @(posedge clk) begin
		tick_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				duty_q.push_back(predict_duty(target_count, left_count, right_count));
				ticks_taken++;
			end
			if (!(in_valid && in_stall)) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (tick_q.size() != 0) begin
					nxt = tick_q.pop_front();
					in_valid     <= 1'b1;
					target_count <= nxt.target;
					left_count   <= nxt.left;
					right_count  <= nxt.right;
					send_gap     <= idle_on ? $urandom_range(0, MAX_IDLE) : 0;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// monitor: random stall per result, long hold-off on request
	always @(posedge clk) begin
		int wait_left;
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_wait <= 0;
		end else begin
			wait_left = recv_wait;
			if (out_valid && !out_stall) begin
				check_duty({duty_left, duty_right, move_done});
				wait_left = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
			end else if (out_valid && wait_left != 0)
				wait_left = wait_left - 1;
			recv_wait <= wait_left;
			out_stall <= hold_on || (wait_left != 0);
		end
	end

	// receiver backs off long enough for the block to fill and stall its input
	initial begin
		wait (ticks_taken >= HOLD_AT);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		hold_on <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic queue_tick(input int tgt, input int lc, input int rc);
		tick_t t;
		t.target = COUNT_BITS'(tgt);
		t.left   = COUNT_BITS'(lc);
		t.right  = COUNT_BITS'(rc);
		tick_q.push_back(t);
		ticks_sent++;
	endtask

	// one move: counts climb toward the target, with overshoot and the odd backward jump
	task automatic queue_move();
		int tgt;
		int lc;
		int rc;
		int step;
		int n;
		tgt  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, CNT_MAX) : $urandom_range(1, 300);
		lc   = $urandom_range(0, tgt / 4);
		rc   = $urandom_range(0, tgt / 4);
		step = tgt / 12 + 1;
		n    = 0;
		while (n < 60) begin
			queue_tick(tgt, lc, rc);
			n++;
			if (lc >= tgt && rc >= tgt)
				break;
			lc = lc + $urandom_range(0, step);
			rc = rc + $urandom_range(0, step);
			if ($urandom_range(0, 9) == 0)
				lc = lc + 4 * step;
			if ($urandom_range(0, 9) == 0)
				rc = rc + 4 * step;
			if ($urandom_range(0, 19) == 0)
				rc = rc / 2;
			if ($urandom_range(0, 19) == 0)
				lc = lc / 2;
			if (lc > CNT_MAX)
				lc = CNT_MAX;
			if (rc > CNT_MAX)
				rc = CNT_MAX;
		end
	endtask

	task automatic queue_random(input int n);
		int start;
		start = ticks_sent;
		while (ticks_sent - start < n) begin
			if ($urandom_range(0, 4) == 0)
				queue_tick($urandom, $urandom, $urandom);
			else
				queue_move();
		end
	endtask

	// run with one wheel far past the target so its accumulator goes deep negative
	task automatic queue_overshoot(input bit on_right);
		int tgt;
		int over;
		for (int i = 0; i < SAT_TICKS; i++) begin
			tgt  = $urandom_range(1, 3);
			over = $urandom_range(CNT_MAX - 15, CNT_MAX);
			if (on_right)
				queue_tick(tgt, 0, over);
			else
				queue_tick(tgt, over, 0);
		end
		// error jumps to -1, derivative swings up against the large negative accumulator
		if (on_right) begin
			queue_tick(1, 0, 2);
			queue_tick(1, 0, 2);
		end else begin
			queue_tick(1, 2, 0);
			queue_tick(1, 2, 0);
		end
		queue_tick(1, 1, 1);
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (ticks_taken != ticks_sent || duty_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// caller sits on a rising edge; valid is left high for a back-to-back write
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_GAIN_P:         kp_cfg     = data[GAIN_W-1:0];
			REG_GAIN_I:         ki_cfg     = data[GAIN_W-1:0];
			REG_GAIN_D:         kd_cfg     = data[GAIN_W-1:0];
			REG_INTEGRAL_LIMIT: lim_cfg    = data[LIM_W-1:0];
			REG_OUTPUT_SCALE:   scale_cfg  = data[GAIN_W-1:0];
			REG_PWM_PERIOD:     period_cfg = data[DUTY_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(input logic [CFG_DAT_W-1:0] kp, ki, kd, lim, scale, period);
		cfg_write(REG_GAIN_P, kp);
		cfg_write(REG_GAIN_I, ki);
		cfg_write(REG_GAIN_D, kd);
		cfg_write(REG_INTEGRAL_LIMIT, lim);
		cfg_write(REG_OUTPUT_SCALE, scale);
		cfg_write(REG_PWM_PERIOD, period);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// corner ticks at reset settings
		queue_tick(0, 0, 0);
		queue_tick(CNT_MAX, 0, 0);
		queue_tick(CNT_MAX, 0, 0);
		queue_tick(CNT_MAX, CNT_MAX, 0);
		queue_tick(100, 200, 50);
		queue_tick(100, 200, 50);
		queue_tick(100, 300, 99);
		queue_tick(100, CNT_MAX, 0);
		queue_tick(100, 101, 99);
		queue_tick(100, 100, 100);
		queue_tick(1, CNT_MAX, 0);
		queue_tick(1, 0, CNT_MAX);
		queue_tick(0, CNT_MAX, CNT_MAX);
		queue_tick(CNT_MAX, CNT_MAX - 1, CNT_MAX - 1);
		queue_tick(CNT_MAX, CNT_MAX, CNT_MAX);
		queue_tick(2048, 2047, 2049);
		queue_tick(2048, 2049, 2047);
		queue_tick(2048, 2048, 2048);
		queue_tick('hAAA, 'h555, 'hAAA);
		queue_tick('h555, 'hAAA, 'h555);
		queue_tick(1, 0, 0);
		queue_tick(1, 1, 0);
		queue_tick(1, 0, 1);
		wait_drained();

		// random full-width data words, spare indexes included
		cfg_write(REG_SPARE_6, CFG_DAT_W'($urandom));
		cfg_write(REG_SPARE_7, CFG_DAT_W'($urandom));
		load_settings(CFG_DAT_W'($urandom), CFG_DAT_W'($urandom), CFG_DAT_W'($urandom),
			CFG_DAT_W'($urandom), CFG_DAT_W'($urandom), CFG_DAT_W'($urandom));
		queue_random(300);
		wait_drained();

		// everything at its maximum, no idling
		idle_on <= 1'b0;
		load_settings('hFFFF, 'hFFFF, 'hFFFF, 'h7FFFFF, 'hFFFF, 'hFFFF);
		queue_random(250);
		wait_drained();

		idle_on <= 1'b1;
		load_settings(0, 0, 0, 0, 0, 1);
		queue_random(100);
		wait_drained();

		// zero period forces every duty to 0
		load_settings(CFG_DAT_W'(GAIN_P_RST), CFG_DAT_W'(GAIN_I_RST), CFG_DAT_W'(GAIN_D_RST),
			CFG_DAT_W'(LIMIT_RST), CFG_DAT_W'(SCALE_RST), 0);
		queue_random(100);
		wait_drained();

		load_settings(1, 1, 1, 1, 1, 1);
		queue_random(150);
		wait_drained();

		repeat (2) begin
			load_settings(CFG_DAT_W'($urandom_range(0, 8191)),
				CFG_DAT_W'($urandom_range(0, 8191)), CFG_DAT_W'($urandom_range(0, 8191)),
				CFG_DAT_W'($urandom), CFG_DAT_W'($urandom_range(0, 8000)),
				CFG_DAT_W'($urandom));
			queue_random(200);
			wait_drained();
		end

		idle_on <= 1'b0;
		load_settings(0, 1, 'hFFFF, 'h7FFFFF, 1, 'hFFFF);
		queue_overshoot(1'b0);
		wait_drained();
		queue_overshoot(1'b1);
		wait_drained();

		idle_on <= 1'b1;
		load_settings(CFG_DAT_W'($urandom), CFG_DAT_W'($urandom), CFG_DAT_W'($urandom),
			CFG_DAT_W'($urandom), CFG_DAT_W'($urandom), CFG_DAT_W'($urandom));
		queue_random(150);
		wait_drained();

		if (err_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: sim.f
rtl/dwpp_pkg.sv
rtl/dual_wheel_pid_position_top.sv
rtl/dwpp_checker.sv
dv/tb_top.sv
